// File: src/scr_pkg.sv
// ----------------------------------------------------------------------------
// scr_pkg
// Shared constants and types of the sphere collision response pipeline.
// ----------------------------------------------------------------------------
package scr_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int LANES = 3;

  typedef enum logic [1:0] {
    ST_NONE       = 2'd0,
    ST_CONTACT    = 2'd1,
    ST_COINCIDENT = 2'd2
  } status_t;

endpackage

// File: src/scr_if.sv
// ----------------------------------------------------------------------------
// scr_if
// Request and response channels of the sphere collision response block.
// ----------------------------------------------------------------------------
interface scr_pair_if import scr_pkg::*; #(parameter int W = WORD_BITS_DEF);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] offset_x;
  logic signed [W-1:0] offset_y;
  logic signed [W-1:0] offset_z;
  logic signed [W-1:0] first_vel_x;
  logic signed [W-1:0] first_vel_y;
  logic signed [W-1:0] first_vel_z;
  logic signed [W-1:0] second_vel_x;
  logic signed [W-1:0] second_vel_y;
  logic signed [W-1:0] second_vel_z;
  logic        [W-2:0] first_radius;
  logic        [W-2:0] second_radius;

  modport source (
    output valid, offset_x, offset_y, offset_z, first_vel_x, first_vel_y, first_vel_z,
    output second_vel_x, second_vel_y, second_vel_z, first_radius, second_radius,
    input  ready
  );
  modport sink (
    input  valid, offset_x, offset_y, offset_z, first_vel_x, first_vel_y, first_vel_z,
    input  second_vel_x, second_vel_y, second_vel_z, first_radius, second_radius,
    output ready
  );
endinterface

interface scr_resp_if import scr_pkg::*; #(parameter int W = WORD_BITS_DEF);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] new_first_vel_x;
  logic signed [W-1:0] new_first_vel_y;
  logic signed [W-1:0] new_first_vel_z;
  logic signed [W-1:0] new_second_vel_x;
  logic signed [W-1:0] new_second_vel_y;
  logic signed [W-1:0] new_second_vel_z;
  status_t             contact_status;

  modport source (
    output valid, new_first_vel_x, new_first_vel_y, new_first_vel_z,
    output new_second_vel_x, new_second_vel_y, new_second_vel_z, contact_status,
    input  ready
  );
  modport sink (
    input  valid, new_first_vel_x, new_first_vel_y, new_first_vel_z,
    input  new_second_vel_x, new_second_vel_y, new_second_vel_z, contact_status,
    output ready
  );
endinterface

// File: src/sphere_collision_response.sv
// ----------------------------------------------------------------------------
// sphere_collision_response
// Equal mass elastic collision of a sphere pair in signed fixed point.
//
//   channel  role    contents
//   pair     sink    center offset, both velocities, both radii
//   resp     source  both new velocities, contact status
//
// One request per cycle while resp is not stalled; the pipeline holds
// five front stages, WORD_BITS + 2 divider stages (a load stage, then one
// quotient bit each) and the output register.
// Synchronous reset clears all valid bits; payload registers are not reset.
// Each stage holds while its successor is full and stalled; bubbles close up.
// ----------------------------------------------------------------------------
module sphere_collision_response import scr_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  scr_pair_if.sink   pair,
  scr_resp_if.source resp
);

  localparam int W = WORD_BITS;

  logic signed [W-1:0]   d [LANES];
  logic signed [W-1:0]   v1 [LANES];
  logic signed [W-1:0]   v2 [LANES];

  logic                  f_valid;
  logic                  f_ready;
  logic signed [3*W+1:0] f_p [LANES];
  logic        [2*W-1:0] f_den;
  status_t               f_status;
  logic signed [W-1:0]   f_v1 [LANES];
  logic signed [W-1:0]   f_v2 [LANES];

  logic                  div_valid;
  logic                  div_ready;
  logic        [W:0]     div_q [LANES];
  logic                  div_neg [LANES];
  status_t               div_status;
  logic signed [W-1:0]   div_v1 [LANES];
  logic signed [W-1:0]   div_v2 [LANES];

  logic signed [W-1:0]   nv1 [LANES];
  logic signed [W-1:0]   nv2 [LANES];

  assign d[0]  = pair.offset_x;
  assign d[1]  = pair.offset_y;
  assign d[2]  = pair.offset_z;
  assign v1[0] = pair.first_vel_x;
  assign v1[1] = pair.first_vel_y;
  assign v1[2] = pair.first_vel_z;
  assign v2[0] = pair.second_vel_x;
  assign v2[1] = pair.second_vel_y;
  assign v2[2] = pair.second_vel_z;

  scr_front #(.W(W)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (pair.valid),
    .in_ready   (pair.ready),
    .d          (d),
    .v1         (v1),
    .v2         (v2),
    .r1         (pair.first_radius),
    .r2         (pair.second_radius),
    .out_valid  (f_valid),
    .out_ready  (f_ready),
    .out_p      (f_p),
    .out_den    (f_den),
    .out_status (f_status),
    .out_v1     (f_v1),
    .out_v2     (f_v2)
  );

  scr_div #(.W(W)) u_div (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (f_valid),
    .in_ready   (f_ready),
    .p          (f_p),
    .den        (f_den),
    .status     (f_status),
    .v1         (f_v1),
    .v2         (f_v2),
    .out_valid  (div_valid),
    .out_ready  (div_ready),
    .out_q      (div_q),
    .out_neg    (div_neg),
    .out_status (div_status),
    .out_v1     (div_v1),
    .out_v2     (div_v2)
  );

  scr_sat #(.W(W)) u_sat (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (div_valid),
    .in_ready   (div_ready),
    .q          (div_q),
    .neg        (div_neg),
    .status     (div_status),
    .v1         (div_v1),
    .v2         (div_v2),
    .out_valid  (resp.valid),
    .out_ready  (resp.ready),
    .nv1        (nv1),
    .nv2        (nv2),
    .out_status (resp.contact_status)
  );

  assign resp.new_first_vel_x  = nv1[0];
  assign resp.new_first_vel_y  = nv1[1];
  assign resp.new_first_vel_z  = nv1[2];
  assign resp.new_second_vel_x = nv2[0];
  assign resp.new_second_vel_y = nv2[1];
  assign resp.new_second_vel_z = nv2[2];

`ifndef SYNTHESIS
  a_resp_hold: assert property (@(posedge clk) disable iff (rst)
    resp.valid && !resp.ready |=>
      resp.valid && $stable(resp.new_first_vel_x) && $stable(resp.new_second_vel_x) &&
      $stable(resp.contact_status))
    else $error("response changed under stall");

  a_coincident: assert property (@(posedge clk) disable iff (rst)
    f_valid |-> ((f_den == '0) == (f_status == ST_COINCIDENT)))
    else $error("coincident status mismatch");

  a_div_hold: assert property (@(posedge clk) disable iff (rst)
    div_valid && !div_ready |=>
      div_valid && $stable(div_q[0]) && $stable(div_q[1]) && $stable(div_q[2]))
    else $error("divider output changed under stall");
`endif

endmodule

// File: src/scr_front.sv
// ----------------------------------------------------------------------------
// scr_front
// Five stage front end: squares, dot products, contact test and the
// split product of the impulse numerator with each offset component.
// ----------------------------------------------------------------------------
module scr_front import scr_pkg::*; #(
  parameter int W = WORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [W-1:0]   d [LANES],
  input  logic signed [W-1:0]   v1 [LANES],
  input  logic signed [W-1:0]   v2 [LANES],
  input  logic        [W-2:0]   r1,
  input  logic        [W-2:0]   r2,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [3*W+1:0] out_p [LANES],
  output logic        [2*W-1:0] out_den,
  output status_t               out_status,
  output logic signed [W-1:0]   out_v1 [LANES],
  output logic signed [W-1:0]   out_v2 [LANES]
);

  localparam int DW = 2 * W;
  localparam int NW = 2 * W + 2;
  localparam int LB = W + 1;
  localparam int HB = NW - LB;
  localparam int PW = 3 * W + 2;
  localparam int NST = 5;

  logic vld [NST];
  logic en  [NST];

  // stage registers
  logic signed [W-1:0]    d1 [LANES], d2 [LANES], d3 [LANES];
  logic signed [W-1:0]    a1 [LANES], a2 [LANES], a3 [LANES], a4 [LANES], a5 [LANES];
  logic signed [W-1:0]    b1 [LANES], b2 [LANES], b3 [LANES], b4 [LANES], b5 [LANES];
  logic signed [W:0]      df1 [LANES];
  logic        [DW-1:0]   sq1 [LANES];
  logic        [W-1:0]    rs1;
  logic signed [DW:0]     pr2 [LANES];
  logic        [DW-1:0]   den2, den3, den4, den5;
  logic        [DW-1:0]   reach2;
  logic signed [NW-1:0]   num3;
  status_t                st3, st4, st5;
  logic signed [LB+W:0]   pl4 [LANES];
  logic signed [HB+W-1:0] ph4 [LANES];
  logic signed [PW-1:0]   p5 [LANES];

  // combinational terms
  logic signed [W:0]      df_c [LANES];
  logic signed [DW-1:0]   sq_c [LANES];
  logic signed [DW:0]     pr_c [LANES];
  logic        [DW-1:0]   reach_c;
  logic signed [LB+W:0]   pl_c [LANES];
  logic signed [HB+W-1:0] ph_c [LANES];
  logic signed [PW-1:0]   p_c [LANES];
  status_t                st_c;

  genvar k;
  generate
    for (k = 0; k < NST; k++) begin : g_en
      if (k == NST - 1) begin : g_last
        assign en[k] = !vld[k] || out_ready;
      end else begin : g_mid
        assign en[k] = !vld[k] || en[k+1];
      end
    end
  endgenerate

  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NST; s++) vld[s] <= 1'b0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int s = 1; s < NST; s++) begin
        if (en[s]) vld[s] <= vld[s-1];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      df_c[i] = (W+1)'(v2[i]) - (W+1)'(v1[i]);
      sq_c[i] = d[i] * d[i];
      pr_c[i] = df1[i] * d1[i];
      pl_c[i] = $signed({1'b0, num3[LB-1:0]}) * d3[i];
      ph_c[i] = $signed(num3[NW-1:LB]) * d3[i];
      p_c[i]  = (PW'(ph4[i]) <<< LB) + PW'(pl4[i]);
    end
    reach_c = rs1 * rs1;
    if (den2 == '0) begin
      st_c = ST_COINCIDENT;
    end else if (den2 > reach2) begin
      st_c = ST_NONE;
    end else begin
      st_c = ST_CONTACT;
    end
  end

  // stage 1: velocity difference, squared offsets, radius sum
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < LANES; i++) begin
        d1[i]  <= d[i];
        a1[i]  <= v1[i];
        b1[i]  <= v2[i];
        df1[i] <= df_c[i];
        sq1[i] <= DW'(sq_c[i]);
      end
      rs1 <= W'(r1) + W'(r2);
    end
  end

  // stage 2: dot product terms, squared length, squared reach
  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < LANES; i++) begin
        d2[i]  <= d1[i];
        a2[i]  <= a1[i];
        b2[i]  <= b1[i];
        pr2[i] <= pr_c[i];
      end
      den2   <= sq1[0] + sq1[1] + sq1[2];
      reach2 <= reach_c;
    end
  end

  // stage 3: numerator sum and contact test
  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int i = 0; i < LANES; i++) begin
        d3[i] <= d2[i];
        a3[i] <= a2[i];
        b3[i] <= b2[i];
      end
      num3 <= NW'(pr2[0]) + NW'(pr2[1]) + NW'(pr2[2]);
      den3 <= den2;
      st3  <= st_c;
    end
  end

  // stage 4: partial products of numerator times offset
  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int i = 0; i < LANES; i++) begin
        a4[i]  <= a3[i];
        b4[i]  <= b3[i];
        pl4[i] <= pl_c[i];
        ph4[i] <= ph_c[i];
      end
      den4 <= den3;
      st4  <= st3;
    end
  end

  // stage 5: combine partial products
  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int i = 0; i < LANES; i++) begin
        a5[i] <= a4[i];
        b5[i] <= b4[i];
        p5[i] <= p_c[i];
      end
      den5 <= den4;
      st5  <= st4;
    end
  end

  assign out_valid  = vld[NST-1];
  assign out_den    = den5;
  assign out_status = st5;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      out_p[i]  = p5[i];
      out_v1[i] = a5[i];
      out_v2[i] = b5[i];
    end
  end

endmodule

// File: src/scr_div.sv
// ----------------------------------------------------------------------------
// scr_div
// Pipelined restoring divider, three lanes in lock step, one quotient bit
// per stage after the load stage, over a shared divisor.
// ----------------------------------------------------------------------------
module scr_div import scr_pkg::*; #(
  parameter int W = WORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [3*W+1:0] p [LANES],
  input  logic        [2*W-1:0] den,
  input  status_t               status,
  input  logic signed [W-1:0]   v1 [LANES],
  input  logic signed [W-1:0]   v2 [LANES],
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic        [W:0]     out_q [LANES],
  output logic                  out_neg [LANES],
  output status_t               out_status,
  output logic signed [W-1:0]   out_v1 [LANES],
  output logic signed [W-1:0]   out_v2 [LANES]
);

  localparam int DW = 2 * W;
  localparam int PW = 3 * W + 2;
  localparam int QB = W + 1;
  localparam int NS = QB + 1;

  logic                vld [NS];
  logic                en  [NS];
  logic [DW-1:0]       rem [NS][LANES];
  logic [QB-1:0]       lo  [NS][LANES];
  logic [QB-1:0]       q   [NS][LANES];
  logic                ng  [NS][LANES];
  logic [DW-1:0]       dv  [NS];
  status_t             st  [NS];
  logic signed [W-1:0] a   [NS][LANES];
  logic signed [W-1:0] b   [NS][LANES];

  logic [PW-1:0]       mag [LANES];

  genvar k;
  generate
    for (k = 0; k < NS; k++) begin : g_en
      if (k == NS - 1) begin : g_last
        assign en[k] = !vld[k] || out_ready;
      end else begin : g_mid
        assign en[k] = !vld[k] || en[k+1];
      end
    end
  endgenerate

  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NS; s++) vld[s] <= 1'b0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int s = 1; s < NS; s++) begin
        if (en[s]) vld[s] <= vld[s-1];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      mag[i] = p[i][PW-1] ? PW'(-p[i]) : PW'(p[i]);
    end
  end

  // quotient fits QB bits, so the top of the magnitude starts below the divisor
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < LANES; i++) begin
        rem[0][i] <= mag[i][QB +: DW];
        lo[0][i]  <= mag[i][QB-1:0];
        q[0][i]   <= '0;
        ng[0][i]  <= p[i][PW-1];
        a[0][i]   <= v1[i];
        b[0][i]   <= v2[i];
      end
      dv[0] <= den;
      st[0] <= status;
    end
  end

  generate
    for (k = 1; k < NS; k++) begin : g_stage
      logic [DW:0] trial [LANES];
      logic        ge    [LANES];

      always_comb begin
        for (int i = 0; i < LANES; i++) begin
          trial[i] = {rem[k-1][i], lo[k-1][i][QB-1]};
          ge[i]    = trial[i] >= {1'b0, dv[k-1]};
        end
      end

      always_ff @(posedge clk) begin
        if (en[k]) begin
          for (int i = 0; i < LANES; i++) begin
            rem[k][i] <= ge[i] ? DW'(trial[i] - {1'b0, dv[k-1]}) : DW'(trial[i]);
            lo[k][i]  <= lo[k-1][i] << 1;
            q[k][i]   <= {q[k-1][i][QB-2:0], ge[i]};
            ng[k][i]  <= ng[k-1][i];
            a[k][i]   <= a[k-1][i];
            b[k][i]   <= b[k-1][i];
          end
          dv[k] <= dv[k-1];
          st[k] <= st[k-1];
        end
      end
    end
  endgenerate

  assign out_valid  = vld[NS-1];
  assign out_status = st[NS-1];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      out_q[i]   = q[NS-1][i];
      out_neg[i] = ng[NS-1][i];
      out_v1[i]  = a[NS-1][i];
      out_v2[i]  = b[NS-1][i];
    end
  end

endmodule

// File: src/scr_sat.sv
// ----------------------------------------------------------------------------
// scr_sat
// On contact applies the signed velocity change to both spheres and saturates;
// otherwise passes the velocities through. The output register holds the response.
// ----------------------------------------------------------------------------
module scr_sat import scr_pkg::*; #(
  parameter int W = WORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic        [W:0]   q [LANES],
  input  logic                neg [LANES],
  input  status_t             status,
  input  logic signed [W-1:0] v1 [LANES],
  input  logic signed [W-1:0] v2 [LANES],
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [W-1:0] nv1 [LANES],
  output logic signed [W-1:0] nv2 [LANES],
  output status_t             out_status
);

  localparam logic signed [W+2:0] SMAX = {4'b0000, {(W-1){1'b1}}};
  localparam logic signed [W+2:0] SMIN = {4'b1111, {(W-1){1'b0}}};

  logic                ovld;
  logic                en;
  logic signed [W+2:0] dl [LANES];
  logic signed [W+2:0] s1 [LANES];
  logic signed [W+2:0] s2 [LANES];

  function automatic logic signed [W-1:0] sat(input logic signed [W+2:0] s);
    logic signed [W-1:0] r;
    if (s > SMAX) begin
      r = W'(SMAX);
    end else if (s < SMIN) begin
      r = W'(SMIN);
    end else begin
      r = W'(s);
    end
    return r;
  endfunction

  assign en       = !ovld || out_ready;
  assign in_ready = en;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      dl[i] = neg[i] ? -$signed({2'b00, q[i]}) : $signed({2'b00, q[i]});
      s1[i] = (W+3)'(v1[i]) + dl[i];
      s2[i] = (W+3)'(v2[i]) - dl[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovld <= 1'b0;
    end else if (en) begin
      ovld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < LANES; i++) begin
        if (status == ST_CONTACT) begin
          nv1[i] <= sat(s1[i]);
          nv2[i] <= sat(s2[i]);
        end else begin
          nv1[i] <= v1[i];
          nv2[i] <= v2[i];
        end
      end
      out_status <= status;
    end
  end

  assign out_valid = ovld;

endmodule
